// ===== rtl/core/salsa20_stream_cipher_defines.svh =====
// assertion macros used by the checker file salsa_checker.sv
// no dependencies
`ifndef SALSA20_STREAM_CIPHER_DEFINES_SVH
`define SALSA20_STREAM_CIPHER_DEFINES_SVH

// implication checked on every clock, off during reset
`define SLS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SLS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/salsa_pkg.sv =====
// types and constants for the salsa20 stream cipher
// no dependencies
package salsa_pkg;

	localparam int BLOCK_BYTES = 64;
	localparam int NUM_REGS = 6;
	localparam int QR_STEPS = 80;

	localparam logic [31:0] SIGMA0 = 32'h61707865;
	localparam logic [31:0] SIGMA1 = 32'h3320646e;
	localparam logic [31:0] SIGMA2 = 32'h79622d32;
	localparam logic [31:0] SIGMA3 = 32'h6b206574;

	localparam logic [2:0] REG_KEY0 = 3'd0;
	localparam logic [2:0] REG_KEY1 = 3'd1;
	localparam logic [2:0] REG_KEY2 = 3'd2;
	localparam logic [2:0] REG_KEY3 = 3'd3;
	localparam logic [2:0] REG_NONCE = 3'd4;
	localparam logic [2:0] REG_CTR = 3'd5;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       message_end;
	} in_item_t;

	typedef struct packed {
		logic [7:0] result_byte;
		logic       message_end_out;
	} out_item_t;

	typedef logic [15:0][31:0] state_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROUND,
		ST_FINAL
	} ctrl_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic round;
		logic finish;
		logic [6:0] qr_idx;
	} dp_cmd_t;

	function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
		rotl = (v << n) | (v >> (32 - n));
	endfunction

endpackage

// ===== rtl/core/salsa_ctrl.sv =====
// round sequencer: starts a block when the buffer is empty, steps 80 quarter-rounds
// depends on salsa_pkg
module salsa_ctrl
	import salsa_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      need_block,
	input  logic      flush,
	output dp_cmd_t   cmd
);

	ctrl_state_t state_q, state_d;
	logic [6:0] idx_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (need_block && !flush) state_d = ST_ROUND;
			ST_ROUND: if (flush) state_d = ST_IDLE;
				else if (idx_q == 7'(QR_STEPS - 1)) state_d = ST_FINAL;
			ST_FINAL: state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_ROUND) idx_q <= idx_q + 7'd1;
			else idx_q <= '0;
		end
	end

	// outputs
	always_comb begin
		cmd = '0;
		cmd.qr_idx = idx_q;
		case (state_q)
			ST_IDLE:  cmd.load = need_block && !flush;
			ST_ROUND: cmd.round = !flush;
			ST_FINAL: cmd.finish = !flush;
			default:  cmd = '0;
		endcase
	end

endmodule

// ===== rtl/core/salsa_dp.sv =====
// datapath: state words, one quarter-round per cycle, finished block read as keystream
// depends on salsa_pkg
module salsa_dp
	import salsa_pkg::*;
(
	input  logic          clk,
	input  dp_cmd_t       cmd,
	input  logic [255:0]  key,
	input  logic [63:0]   nonce,
	input  logic [63:0]   counter,
	input  logic [5:0]    rd_idx,
	output logic [7:0]    ks_byte
);

	state_t x_q, in_q;
	state_t init;
	logic [3:0] a, b, c, d;
	logic [31:0] nb, nc, nd, na;
	state_t x_n;
	logic [31:0] ks_word;

	// initial state words
	always_comb begin
		init[0] = SIGMA0;
		init[1] = key[31:0];
		init[2] = key[63:32];
		init[3] = key[95:64];
		init[4] = key[127:96];
		init[5] = SIGMA1;
		init[6] = nonce[31:0];
		init[7] = nonce[63:32];
		init[8] = counter[31:0];
		init[9] = counter[63:32];
		init[10] = SIGMA2;
		init[11] = key[159:128];
		init[12] = key[191:160];
		init[13] = key[223:192];
		init[14] = key[255:224];
		init[15] = SIGMA3;
	end

	// word selection for this quarter-round
	always_comb begin
		case (cmd.qr_idx[2:0])
			3'd0: begin a = 4'd0;  b = 4'd4;  c = 4'd8;  d = 4'd12; end
			3'd1: begin a = 4'd5;  b = 4'd9;  c = 4'd13; d = 4'd1;  end
			3'd2: begin a = 4'd10; b = 4'd14; c = 4'd2;  d = 4'd6;  end
			3'd3: begin a = 4'd15; b = 4'd3;  c = 4'd7;  d = 4'd11; end
			3'd4: begin a = 4'd0;  b = 4'd1;  c = 4'd2;  d = 4'd3;  end
			3'd5: begin a = 4'd5;  b = 4'd6;  c = 4'd7;  d = 4'd4;  end
			3'd6: begin a = 4'd10; b = 4'd11; c = 4'd8;  d = 4'd9;  end
			default: begin a = 4'd15; b = 4'd12; c = 4'd13; d = 4'd14; end
		endcase
		nb = x_q[b] ^ rotl(x_q[a] + x_q[d], 7);
		nc = x_q[c] ^ rotl(nb + x_q[a], 9);
		nd = x_q[d] ^ rotl(nc + nb, 13);
		na = x_q[a] ^ rotl(nd + nc, 18);
		x_n = x_q;
		x_n[a] = na;
		x_n[b] = nb;
		x_n[c] = nc;
		x_n[d] = nd;
	end

	// load, round steps, then input words added back in place
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q <= init;
			in_q <= init;
		end else if (cmd.round) begin
			x_q <= x_n;
		end else if (cmd.finish) begin
			for (int i = 0; i < 16; i++) x_q[i] <= x_q[i] + in_q[i];
		end
	end

	// keystream byte, little-endian within each word
	assign ks_word = x_q[rd_idx[5:2]];
	assign ks_byte = ks_word[8*rd_idx[1:0] +: 8];

endmodule

// ===== rtl/core/salsa20_stream_cipher.sv =====
// Salsa20/20 stream cipher, one byte per request, with APB configuration.
// Each 64-byte keystream block takes one load, 80 quarter-rounds on a
// single shared quarter-round unit and one final add; bytes then flow one per cycle
// for 64 requests while the output is not stalled, and requests wait while a block is built.
// Any register write reloads the block counter and discards the buffered keystream.
module salsa20_stream_cipher
	import salsa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data
);

	logic [63:0] regs_q [NUM_REGS];
	logic [63:0] ctr_q;
	logic [6:0]  pos_q;
	logic        wr, flush, need_block, in_acc, out_free;
	logic [2:0]  ridx;
	dp_cmd_t     cmd;
	logic [7:0]  ks;

	assign pready = 1'b1;
	assign ridx = paddr[5:3];
	assign wr = psel && penable && pwrite && (paddr[5:3] < 3'(NUM_REGS));
	assign flush = wr;
	assign need_block = pos_q[6];

	// register read
	always_comb begin
		prdata = '0;
		if (ridx < 3'(NUM_REGS)) prdata = regs_q[ridx];
	end

	// output register frees when empty or taken
	assign out_free = !out_valid || !out_stall;
	assign in_stall = pos_q[6] || !out_free;
	assign in_acc = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) regs_q[i] <= '0;
			ctr_q <= '0;
			pos_q <= 7'(BLOCK_BYTES);
			out_valid <= 1'b0;
		end else begin
			if (wr) begin
				regs_q[ridx] <= pwdata;
				ctr_q <= (ridx == REG_CTR) ? pwdata : regs_q[REG_CTR];
				pos_q <= 7'(BLOCK_BYTES);
			end else begin
				if (cmd.finish) begin
					ctr_q <= ctr_q + 64'd1;
					pos_q <= '0;
				end else if (in_acc) begin
					pos_q <= pos_q + 7'd1;
				end
			end
			if (in_acc) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			out_data.result_byte <= in_data.data_byte ^ ks;
			out_data.message_end_out <= in_data.message_end;
		end
	end

	salsa_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.need_block (need_block),
		.flush      (flush),
		.cmd        (cmd)
	);

	salsa_dp u_dp (
		.clk     (clk),
		.cmd     (cmd),
		.key     ({regs_q[REG_KEY3], regs_q[REG_KEY2], regs_q[REG_KEY1], regs_q[REG_KEY0]}),
		.nonce   (regs_q[REG_NONCE]),
		.counter (ctr_q),
		.rd_idx  (pos_q[5:0]),
		.ks_byte (ks)
	);

endmodule

// ===== rtl/core/salsa_checker.sv =====
// port-level checks for the salsa20 stream cipher, bound to the top level
// depends on salsa_pkg and salsa20_stream_cipher_defines.svh
`include "salsa20_stream_cipher_defines.svh"

module salsa_checker
	import salsa_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_data,
	input logic      pready
);

	`SLS_ASSERT_IMP(a_pready, clk, arst_n, 1'b1, pready, "pready low")
	`SLS_ASSERT_NXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
	`SLS_ASSERT_NXT(a_produce, clk, arst_n, in_valid && !in_stall, out_valid, "accepted request lost")
	`SLS_ASSERT_IMP(a_full_stall, clk, arst_n, out_valid && out_stall, in_stall, "request taken while output full")

endmodule

bind salsa20_stream_cipher salsa_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data),
	.pready    (pready)
);

// ===== tb/salsa20_stream_cipher_tb.sv =====
// testbench for the salsa20 stream cipher: apb key setup, byte stream checked
// against a bit-accurate salsa20/20 keystream predictor; depends on salsa_pkg and the rtl
module salsa20_stream_cipher_tb;
	import salsa_pkg::*;

	// keystream predictor and store of expected cipher bytes
	class cipher_scoreboard;
		logic [63:0] regs [NUM_REGS];
		logic [63:0] blk_ctr;
		logic [7:0] ks [BLOCK_BYTES];
		int unsigned pos;
		out_item_t expected_bytes [$];
		int unsigned errors;
		int unsigned checked;

		function new();
			foreach (regs[i]) regs[i] = '0;
			blk_ctr = '0;
			pos = BLOCK_BYTES;
			errors = 0;
			checked = 0;
		endfunction

		function void write_reg(int unsigned idx, logic [63:0] val);
			if (idx < NUM_REGS) begin
				regs[idx] = val;
				blk_ctr = regs[REG_CTR];
				pos = BLOCK_BYTES;
			end
		endfunction

		function logic [31:0] rot(logic [31:0] v, int n);
			return (v << n) | (v >> (32 - n));
		endfunction

		function void quarter(ref logic [31:0] s [16], input int a, int b, int c, int d);
			s[b] ^= rot(s[a] + s[d], 7);
			s[c] ^= rot(s[b] + s[a], 9);
			s[d] ^= rot(s[c] + s[b], 13);
			s[a] ^= rot(s[d] + s[c], 18);
		endfunction

		function void gen_block();
			logic [31:0] init [16];
			logic [31:0] x [16];
			logic [31:0] w;
			init[0] = SIGMA0;
			init[1] = regs[REG_KEY0][31:0];
			init[2] = regs[REG_KEY0][63:32];
			init[3] = regs[REG_KEY1][31:0];
			init[4] = regs[REG_KEY1][63:32];
			init[5] = SIGMA1;
			init[6] = regs[REG_NONCE][31:0];
			init[7] = regs[REG_NONCE][63:32];
			init[8] = blk_ctr[31:0];
			init[9] = blk_ctr[63:32];
			init[10] = SIGMA2;
			init[11] = regs[REG_KEY2][31:0];
			init[12] = regs[REG_KEY2][63:32];
			init[13] = regs[REG_KEY3][31:0];
			init[14] = regs[REG_KEY3][63:32];
			init[15] = SIGMA3;
			x = init;
			for (int r = 0; r < 10; r++) begin
				quarter(x, 0, 4, 8, 12);
				quarter(x, 5, 9, 13, 1);
				quarter(x, 10, 14, 2, 6);
				quarter(x, 15, 3, 7, 11);
				quarter(x, 0, 1, 2, 3);
				quarter(x, 5, 6, 7, 4);
				quarter(x, 10, 11, 8, 9);
				quarter(x, 15, 12, 13, 14);
			end
			for (int i = 0; i < 16; i++) begin
				w = x[i] + init[i];
				for (int k = 0; k < 4; k++) ks[4*i+k] = w[8*k +: 8];
			end
			blk_ctr = blk_ctr + 64'd1;
		endfunction

		// note an accepted request
		function void note_request(in_item_t req);
			out_item_t e;
			if (pos >= BLOCK_BYTES) begin
				gen_block();
				pos = 0;
			end
			e.result_byte = req.data_byte ^ ks[pos];
			e.message_end_out = req.message_end;
			pos++;
			expected_bytes.push_back(e);
		endfunction

		// compare one result with the oldest expectation
		function void check_result(out_item_t got);
			out_item_t e;
			checked++;
			if (expected_bytes.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %h", got);
				return;
			end
			e = expected_bytes.pop_front();
			if (got.result_byte !== e.result_byte || got.message_end_out !== e.message_end_out) begin
				errors++;
				if (errors <= 10)
					$display("byte %0d: expected %h/%b got %h/%b", checked,
						e.result_byte, e.message_end_out, got.result_byte, got.message_end_out);
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic psel, penable, pwrite;
	logic [5:0] paddr;
	logic [63:0] pwdata, prdata;
	logic pready;
	logic in_valid, in_stall, out_valid, out_stall;
	in_item_t in_data;
	out_item_t out_data;
	cipher_scoreboard sb;
	int unsigned cycles;
	int unsigned sent;

	salsa20_stream_cipher uut (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// timeout watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 2000000) begin
			$display("timeout after %0d cycles", cycles);
			$display("Mismatches found");
			$finish;
		end
	end

	// result sampling
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check_result(out_data);
	end

	// receiver stall pattern, with calm stretches
	initial begin : rx_side
		int unsigned n;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (($urandom % 4) == 0) begin
				n = $urandom_range(0, 18);
				if (n != 0) begin
					out_stall <= 1'b1;
					repeat (n) @(posedge clk);
					out_stall <= 1'b0;
				end
			end
		end
	end

	task automatic apb_write(logic [2:0] idx, logic [63:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.write_reg(idx, val);
		@(posedge clk);
	endtask

	// one request, with a random gap before it when gaps is set
	task automatic send_byte(logic [7:0] d, logic last, bit gaps);
		int unsigned g;
		g = gaps ? $urandom_range(0, 18) : 0;
		if (($urandom % 3) == 0) g = 0;
		if (g != 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{data_byte: d, message_end: last};
		do @(posedge clk); while (in_stall);
		sb.note_request('{data_byte: d, message_end: last});
		sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.expected_bytes.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	initial begin : main
		logic [63:0] v;
		sb = new();
		sent = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		in_valid = 0; in_data = '0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset key, extreme bytes, end marks, a full block boundary
		send_byte(8'h00, 1'b0, 1'b0);
		send_byte(8'hff, 1'b1, 1'b0);
		send_byte(8'h55, 1'b0, 1'b1);
		send_byte(8'haa, 1'b1, 1'b1);
		for (int i = 0; i < 64; i++) send_byte(i[7:0], i[0], 1'b0);
		drain();

		// all-ones key and counter at the wrap point
		for (int r = 0; r < NUM_REGS; r++) apb_write(r[2:0], '1);
		apb_write(REG_CTR, 64'hffff_ffff_ffff_ffff);
		for (int i = 0; i < 130; i++) send_byte(8'(i * 37), (i % 50) == 49, 1'b1);
		drain();

		// random phases: new keys, nonces and counters, mid-block reloads too
		for (int ph = 0; ph < 6; ph++) begin
			for (int r = 0; r < NUM_REGS; r++) begin
				v = rnd64();
				if (r == REG_CTR && ph == 5) v = 64'hffff_ffff_ffff_fffe;
				if (r == REG_CTR && ph == 4) v = '0;
				apb_write(r[2:0], v);
			end
			for (int i = 0; i < 70; i++)
				send_byte(8'($urandom_range(0, 255)), ($urandom % 16) == 0,
					($urandom % 4) != 0);
			drain();
			// single register rewrite empties the buffer mid-block
			apb_write(3'($urandom_range(0, NUM_REGS - 1)), rnd64());
			for (int i = 0; i < 20; i++)
				send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
			drain();
		end

		$display("sent %0d bytes under the reset key, an all-ones key and random keys,", sent);
		$display("with block boundaries, counter wrap and reloads that empty the buffer");
		if (sb.errors == 0 && sb.expected_bytes.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
